// ===== rtl/radio_txrx_transaction_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Radio transaction controller assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RADIO_TXRX_TRANSACTION_CONTROLLER_TOP_DEFINES_SVH
`define RADIO_TXRX_TRANSACTION_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define RTTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication
`define RTTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/rttc_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio transaction controller package
// Types, codes and reset values shared by the controller modules.
// ----------------------------------------------------------------------------
package rttc_pkg;

   localparam int ELAPSED_BITS_DEFAULT = 16;
   localparam int LEN_W   = 8;
   localparam int WIN_W   = 16;
   localparam int IRQ_W   = 16;
   localparam int TICKS_W = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TICKS_SHIFT = 6;   // 64 ticks per millisecond

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST   = 8'd255;
   localparam logic [WIN_W-1:0] TX_WATCHDOG_RST   = 16'd3500;
   localparam logic [WIN_W-1:0] MAX_RX_WINDOW_RST = 16'd60000;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_WATCHDOG   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RX_WINDOW = 2'd2;

   localparam int IRQ_TX_DONE_POS    = 0;
   localparam int IRQ_RX_DONE_POS    = 1;
   localparam int IRQ_HEADER_ERR_POS = 5;
   localparam int IRQ_CRC_ERR_POS    = 6;
   localparam int IRQ_TIMEOUT_POS    = 9;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_BUSY    = 2'd2;

   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_TX_DONE      = 3'd1;
   localparam logic [2:0] EV_TIMEOUT      = 3'd2;
   localparam logic [2:0] EV_BUS_ERROR    = 3'd3;
   localparam logic [2:0] EV_PACKET       = 3'd4;
   localparam logic [2:0] EV_CRC_ERROR    = 3'd5;
   localparam logic [2:0] EV_HEADER_ERROR = 3'd6;

   typedef enum logic [2:0] {
      OP_START_TX = 3'd0,
      OP_START_RX = 3'd1,
      OP_POLL_TX  = 3'd2,
      OP_POLL_RX  = 3'd3,
      OP_SLEEP    = 3'd4,
      OP_TICK     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TX   = 2'd1,
      MODE_RX   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0]       operation;
      logic [LEN_W-1:0] payload_length;
      logic [WIN_W-1:0] rx_window;
      logic [IRQ_W-1:0] int_flags;
      logic             dio1_level;
      logic             bus_ok;
      logic [LEN_W-1:0] rx_length;
      logic [LEN_W-1:0] rx_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]         status_code;
      logic [2:0]         event_code;
      logic [TICKS_W-1:0] rx_timeout_ticks;
      logic [LEN_W-1:0]   packet_length;
      logic [LEN_W-1:0]   packet_offset;
      logic               clear_irq;
      logic               is_active;
      logic               is_sleeping;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] max_payload;
      logic [WIN_W-1:0] tx_watchdog_ms;
      logic [WIN_W-1:0] max_rx_window_ms;
   } cfg_type;

endpackage

// ===== rtl/rttc_step.sv =====
// ----------------------------------------------------------------------------
// Radio transaction controller step logic
// Decodes one item against the current link state; gives next state and result.
// ----------------------------------------------------------------------------
module rttc_step import rttc_pkg::*; #(
   parameter int ELAPSED_BITS = ELAPSED_BITS_DEFAULT
) (
   input  req_type                  req,
   input  cfg_type                  cfg,
   input  mode_type                 mode,
   input  logic                     asleep,
   input  logic [ELAPSED_BITS-1:0]  elapsed,
   output mode_type                 mode_in,
   output logic                     asleep_in,
   output logic [ELAPSED_BITS-1:0]  elapsed_in,
   output rsp_type                  rsp
);

   localparam int CMP_W = (ELAPSED_BITS > WIN_W) ? ELAPSED_BITS : WIN_W;

   op_type           op;
   logic             active;
   logic             expired;
   logic             tx_bad;
   logic             rx_bad;
   logic             irq_any;
   logic             poll_end;
   logic             poll_clr;
   logic [2:0]       poll_event;
   logic [LEN_W-1:0] poll_len;
   logic [LEN_W-1:0] poll_off;

   assign op = op_type'(req.operation);

   // decode
   always_comb begin
      active   = (mode != MODE_IDLE);
      expired  = (CMP_W'(elapsed) >= CMP_W'(cfg.tx_watchdog_ms));
      tx_bad   = (req.payload_length == '0) || (req.payload_length > cfg.max_payload) || active;
      rx_bad   = (req.rx_window == '0) || (req.rx_window > cfg.max_rx_window_ms) || active;
      irq_any  = (req.int_flags != '0);
      poll_end   = 1'b0;
      poll_clr   = 1'b0;
      poll_event = EV_NONE;
      poll_len   = '0;
      poll_off   = '0;
      if (op == OP_POLL_TX && mode == MODE_TX && (req.dio1_level || expired)) begin
         if (!req.bus_ok) begin
            poll_event = EV_BUS_ERROR;
            poll_end   = 1'b1;
         end else begin
            poll_clr = irq_any;
            if (req.int_flags[IRQ_TX_DONE_POS]) begin
               poll_event = EV_TX_DONE;
               poll_end   = 1'b1;
            end else if (req.int_flags[IRQ_TIMEOUT_POS] || expired) begin
               poll_event = EV_TIMEOUT;
               poll_end   = 1'b1;
            end
         end
      end else if (op == OP_POLL_RX && mode == MODE_RX) begin
         if (!req.bus_ok) begin
            poll_event = EV_BUS_ERROR;
            poll_end   = 1'b1;
         end else if (irq_any) begin
            poll_clr = 1'b1;
            if (req.int_flags[IRQ_CRC_ERR_POS]) begin
               poll_event = EV_CRC_ERROR;
               poll_end   = 1'b1;
            end else if (req.int_flags[IRQ_HEADER_ERR_POS]) begin
               poll_event = EV_HEADER_ERROR;
               poll_end   = 1'b1;
            end else if (req.int_flags[IRQ_TIMEOUT_POS]) begin
               poll_event = EV_TIMEOUT;
               poll_end   = 1'b1;
            end else if (req.int_flags[IRQ_RX_DONE_POS]) begin
               poll_event = EV_PACKET;
               poll_end   = 1'b1;
               poll_len   = (req.rx_length > cfg.max_payload) ? cfg.max_payload : req.rx_length;
               poll_off   = req.rx_offset;
            end
         end
      end
   end

   // next state
   always_comb begin
      mode_in    = mode;
      asleep_in  = asleep;
      elapsed_in = elapsed;
      case (op)
         OP_START_TX: begin
            if (!tx_bad && req.bus_ok) begin
               mode_in    = MODE_TX;
               asleep_in  = 1'b0;
               elapsed_in = '0;
            end
         end
         OP_START_RX: begin
            if (!rx_bad && req.bus_ok) begin
               mode_in   = MODE_RX;
               asleep_in = 1'b0;
            end
         end
         OP_POLL_TX, OP_POLL_RX: begin
            if (poll_end) begin
               mode_in = MODE_IDLE;
            end
         end
         OP_SLEEP: begin
            if (!active && !asleep && req.bus_ok) begin
               asleep_in = 1'b1;
            end
         end
         OP_TICK: begin
            if (elapsed != {ELAPSED_BITS{1'b1}}) begin
               elapsed_in = elapsed + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // result
   always_comb begin
      rsp                  = '0;
      rsp.event_code       = poll_event;
      rsp.clear_irq        = poll_clr;
      rsp.packet_length    = poll_len;
      rsp.packet_offset    = poll_off;
      rsp.is_active        = (mode_in != MODE_IDLE);
      rsp.is_sleeping      = asleep_in;
      case (op)
         OP_START_TX: begin
            rsp.status_code = tx_bad ? ST_INVALID : (!req.bus_ok ? ST_BUSY : ST_OK);
         end
         OP_START_RX: begin
            rsp.status_code = rx_bad ? ST_INVALID : (!req.bus_ok ? ST_BUSY : ST_OK);
            if (!rx_bad && req.bus_ok) begin
               rsp.rx_timeout_ticks = {req.rx_window, TICKS_SHIFT'(0)};
            end
         end
         OP_SLEEP: begin
            rsp.status_code = active ? ST_INVALID :
                              ((!asleep && !req.bus_ok) ? ST_BUSY : ST_OK);
         end
         default: begin
            rsp.status_code = ST_OK;
         end
      endcase
   end

endmodule

// ===== rtl/radio_txrx_transaction_controller_top.sv =====
// ----------------------------------------------------------------------------
// Radio transaction controller top level
// Link mode, sleep flag and transmit watchdog for a packet radio driver.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per operation (start tx/rx, poll tx/rx, sleep, tick),
//            with the interrupt status and bus result of that operation.
//   rsp_*  : exactly one result item per request item, in order.
//   csr_*  : register writes (max payload, tx watchdog, max rx window),
//            taken in the cycle csr_we is high; write only while idle.
//   rsp_valid rises in the cycle after acceptance. One item per cycle is
//   sustained while rsp_ready is high; the limit is the single result register,
//   which frees itself in the same cycle it is taken.
//   A stalled result holds rsp_data; req_ready drops only while a result
//   waits and rsp_ready is low.
//   Synchronous reset: mode idle, awake, elapsed count zero, registers back
//   to 255 / 3500 / 60000, no result pending.
// ----------------------------------------------------------------------------
module radio_txrx_transaction_controller_top import rttc_pkg::*; #(
   parameter int ELAPSED_BITS = ELAPSED_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                 cfg_ff;
   mode_type                mode_ff;
   mode_type                mode_in;
   logic                    asleep_ff;
   logic                    asleep_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff;
   logic [ELAPSED_BITS-1:0] elapsed_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;
   logic                    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   rttc_step #(
      .ELAPSED_BITS (ELAPSED_BITS)
   ) u_step (
      .req        (req_data),
      .cfg        (cfg_ff),
      .mode       (mode_ff),
      .asleep     (asleep_ff),
      .elapsed    (elapsed_ff),
      .mode_in    (mode_in),
      .asleep_in  (asleep_in),
      .elapsed_in (elapsed_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload      <= MAX_PAYLOAD_RST;
         cfg_ff.tx_watchdog_ms   <= TX_WATCHDOG_RST;
         cfg_ff.max_rx_window_ms <= MAX_RX_WINDOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:   cfg_ff.max_payload      <= csr_wdata[LEN_W-1:0];
            CSR_TX_WATCHDOG:   cfg_ff.tx_watchdog_ms   <= csr_wdata[WIN_W-1:0];
            CSR_MAX_RX_WINDOW: cfg_ff.max_rx_window_ms <= csr_wdata[WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         asleep_ff    <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            asleep_ff  <= asleep_in;
            elapsed_ff <= elapsed_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/rttc_checker.sv =====
// ----------------------------------------------------------------------------
// Radio transaction controller port checker
// Assertions on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "radio_txrx_transaction_controller_top_defines.svh"

module rttc_checker import rttc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data
);

   `RTTC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `RTTC_ASSERT_NEXT(a_item_result, clock, reset, req_valid && req_ready, rsp_valid)
   `RTTC_ASSERT_IMPLY(a_ready_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `RTTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `RTTC_ASSERT_IMPLY(a_sleep_idle, clock, reset, rsp_valid, !(rsp_data.is_active && rsp_data.is_sleeping))

endmodule

bind radio_txrx_transaction_controller_top rttc_checker u_rttc_checker (.*);

// ===== dv/radio_txrx_transaction_controller_top_test.sv =====
// ----------------------------------------------------------------------------
// Radio transaction controller testbench
// Drives operation items with random gaps and result back-pressure, predicts
// each result from a local copy of mode, sleep flag, watchdog count and
// registers, and compares every result field in order.
// ----------------------------------------------------------------------------
module radio_txrx_transaction_controller_top_test;
   import rttc_pkg::*;

   // narrow count so a watchdog beyond its range is reachable
   localparam int ELAPSED_W   = 12;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [2:0] OP_UNDEF_A = 3'd6;
   localparam logic [2:0] OP_UNDEF_B = 3'd7;

   localparam logic [15:0] FLAG_TX_DONE = 16'd1 << IRQ_TX_DONE_POS;
   localparam logic [15:0] FLAG_RX_DONE = 16'd1 << IRQ_RX_DONE_POS;
   localparam logic [15:0] FLAG_HDR_ERR = 16'd1 << IRQ_HEADER_ERR_POS;
   localparam logic [15:0] FLAG_CRC_ERR = 16'd1 << IRQ_CRC_ERR_POS;
   localparam logic [15:0] FLAG_TIMEOUT = 16'd1 << IRQ_TIMEOUT_POS;
   localparam logic [15:0] FLAG_DECISIVE =
      FLAG_TX_DONE | FLAG_RX_DONE | FLAG_HDR_ERR | FLAG_CRC_ERR | FLAG_TIMEOUT;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit send_quiet = 1'b0;
   bit hold_rsp = 1'b0;
   int idle_cycles = 0;

   radio_txrx_transaction_controller_top #(.ELAPSED_BITS(ELAPSED_W)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   class txrx_scoreboard;
      logic [LEN_W-1:0]     max_payload;
      logic [WIN_W-1:0]     tx_watchdog_ms;
      logic [WIN_W-1:0]     max_rx_window_ms;
      mode_type             mode;
      bit                   asleep;
      logic [ELAPSED_W-1:0] elapsed_ms;
      rsp_type              expected_rsp_q[$];
      int                   errors;

      function new();
         max_payload = MAX_PAYLOAD_RST;
         tx_watchdog_ms = TX_WATCHDOG_RST;
         max_rx_window_ms = MAX_RX_WINDOW_RST;
         mode = MODE_IDLE;
         asleep = 1'b0;
         elapsed_ms = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_MAX_PAYLOAD:   max_payload = value[LEN_W-1:0];
            CSR_TX_WATCHDOG:   tx_watchdog_ms = value;
            CSR_MAX_RX_WINDOW: max_rx_window_ms = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      // advance the controller state by one item and queue its result
      function void note_request(req_type r);
         rsp_type want;
         bit      active;
         bit      expired;
         want = '0;
         want.status_code = ST_OK;
         want.event_code = EV_NONE;
         active = (mode != MODE_IDLE);
         case (r.operation)
            OP_START_TX: begin
               if (r.payload_length == 0 || r.payload_length > max_payload || active) begin
                  want.status_code = ST_INVALID;
               end else if (!r.bus_ok) begin
                  want.status_code = ST_BUSY;
               end else begin
                  asleep = 1'b0;
                  elapsed_ms = '0;
                  mode = MODE_TX;
               end
            end
            OP_START_RX: begin
               if (r.rx_window == 0 || r.rx_window > max_rx_window_ms || active) begin
                  want.status_code = ST_INVALID;
               end else if (!r.bus_ok) begin
                  want.status_code = ST_BUSY;
               end else begin
                  want.rx_timeout_ticks = TICKS_W'(r.rx_window) << TICKS_SHIFT;
                  asleep = 1'b0;
                  mode = MODE_RX;
               end
            end
            OP_POLL_TX: begin
               if (mode == MODE_TX) begin
                  expired = (WIN_W'(elapsed_ms) >= tx_watchdog_ms);
                  if (r.dio1_level || expired) begin
                     if (!r.bus_ok) begin
                        want.event_code = EV_BUS_ERROR;
                        mode = MODE_IDLE;
                     end else begin
                        want.clear_irq = (r.int_flags != 0);
                        if ((r.int_flags & FLAG_TX_DONE) != 0) begin
                           want.event_code = EV_TX_DONE;
                           mode = MODE_IDLE;
                        end else if ((r.int_flags & FLAG_TIMEOUT) != 0 || expired) begin
                           want.event_code = EV_TIMEOUT;
                           mode = MODE_IDLE;
                        end
                     end
                  end
               end
            end
            OP_POLL_RX: begin
               if (mode == MODE_RX) begin
                  if (!r.bus_ok) begin
                     want.event_code = EV_BUS_ERROR;
                     mode = MODE_IDLE;
                  end else if (r.int_flags != 0) begin
                     want.clear_irq = 1'b1;
                     if ((r.int_flags & FLAG_CRC_ERR) != 0) begin
                        want.event_code = EV_CRC_ERROR;
                        mode = MODE_IDLE;
                     end else if ((r.int_flags & FLAG_HDR_ERR) != 0) begin
                        want.event_code = EV_HEADER_ERROR;
                        mode = MODE_IDLE;
                     end else if ((r.int_flags & FLAG_TIMEOUT) != 0) begin
                        want.event_code = EV_TIMEOUT;
                        mode = MODE_IDLE;
                     end else if ((r.int_flags & FLAG_RX_DONE) != 0) begin
                        want.event_code = EV_PACKET;
                        want.packet_length = (r.rx_length > max_payload) ?
                                             max_payload : r.rx_length;
                        want.packet_offset = r.rx_offset;
                        mode = MODE_IDLE;
                     end
                  end
               end
            end
            OP_SLEEP: begin
               if (active) begin
                  want.status_code = ST_INVALID;
               end else if (!asleep) begin
                  if (!r.bus_ok) begin
                     want.status_code = ST_BUSY;
                  end else begin
                     mode = MODE_IDLE;
                     asleep = 1'b1;
                  end
               end
            end
            OP_TICK: begin
               if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
            end
            default: ;
         endcase
         want.is_active = (mode != MODE_IDLE);
         want.is_sleeping = asleep;
         expected_rsp_q.push_back(want);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp_q.size() == 0) begin
            errors++;
            $display("%0t: result with none pending: expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = expected_rsp_q.pop_front();
         check_field("status_code", 32'(want.status_code), 32'(got.status_code));
         check_field("event_code", 32'(want.event_code), 32'(got.event_code));
         check_field("rx_timeout_ticks", 32'(want.rx_timeout_ticks),
                     32'(got.rx_timeout_ticks));
         check_field("packet_length", 32'(want.packet_length), 32'(got.packet_length));
         check_field("packet_offset", 32'(want.packet_offset), 32'(got.packet_offset));
         check_field("clear_irq", 32'(want.clear_irq), 32'(got.clear_irq));
         check_field("is_active", 32'(want.is_active), 32'(got.is_active));
         check_field("is_sleeping", 32'(want.is_sleeping), 32'(got.is_sleeping));
      endfunction
   endclass

   txrx_scoreboard sb;

   // mostly short, a few long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [7:0] len, logic [15:0] win,
                                        logic [15:0] irq, bit pin, bit bus,
                                        logic [7:0] rlen, logic [7:0] roff);
      req_type r;
      r.operation = op;
      r.payload_length = len;
      r.rx_window = win;
      r.int_flags = irq;
      r.dio1_level = pin;
      r.bus_ok = bus;
      r.rx_length = rlen;
      r.rx_offset = roff;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      pick;
      int      sub;
      r = make_req(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 99) < 12) return r;
      r.bus_ok = ($urandom_range(0, 19) != 0);
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 19);
      case (sb.mode)
         MODE_IDLE: begin
            if (pick < 40) begin
               r.operation = OP_START_TX;
               if (sub == 0) r.payload_length = 0;
               else if (sub == 1) r.payload_length = sb.max_payload;
               else if (sub == 2) r.payload_length = sb.max_payload + 1'b1;
               else if (sub > 3) r.payload_length = 8'($urandom_range(1, sb.max_payload));
            end else if (pick < 75) begin
               r.operation = OP_START_RX;
               if (sub == 0) r.rx_window = 0;
               else if (sub == 1) r.rx_window = sb.max_rx_window_ms;
               else if (sub == 2) r.rx_window = sb.max_rx_window_ms + 1'b1;
               else if (sub > 3) r.rx_window = 16'($urandom_range(1, sb.max_rx_window_ms));
            end else if (pick < 85) begin
               r.operation = OP_SLEEP;
            end else begin
               r.operation = OP_TICK;
            end
         end
         MODE_TX: begin
            if (pick < 45) begin
               r.operation = OP_POLL_TX;
               r.dio1_level = ($urandom_range(0, 2) != 0);
               case ($urandom_range(0, 3))
                  0: r.int_flags = FLAG_TX_DONE | (r.int_flags & ~FLAG_DECISIVE);
                  1: r.int_flags = FLAG_TIMEOUT;
                  2: r.int_flags = '0;
                  default: ;
               endcase
            end else if (pick < 92) begin
               r.operation = OP_TICK;
            end else begin
               r.operation = 3'($urandom_range(0, 4));
               r.payload_length = 8'($urandom_range(1, sb.max_payload));
            end
         end
         default: begin
            if (pick < 55) begin
               r.operation = OP_POLL_RX;
               case ($urandom_range(0, 5))
                  0: r.int_flags = '0;
                  1: r.int_flags = r.int_flags | FLAG_CRC_ERR;
                  2: r.int_flags = (r.int_flags & ~FLAG_CRC_ERR) | FLAG_HDR_ERR;
                  3: r.int_flags = (r.int_flags & ~(FLAG_CRC_ERR | FLAG_HDR_ERR)) |
                                   FLAG_TIMEOUT;
                  4: r.int_flags = (r.int_flags & ~(FLAG_CRC_ERR | FLAG_HDR_ERR |
                                   FLAG_TIMEOUT)) | FLAG_RX_DONE;
                  default: r.int_flags = r.int_flags & ~FLAG_DECISIVE;
               endcase
            end else if (pick < 85) begin
               r.operation = OP_TICK;
            end else begin
               r.operation = 3'($urandom_range(0, 4));
               r.rx_window = 16'($urandom_range(1, sb.max_rx_window_ms));
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_req(input req_type r);
      int gap;
      gap = (send_quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic configure(input logic [7:0] mp, input logic [15:0] wd, input logic [15:0] rw);
      drain();
      write_csr(CSR_MAX_PAYLOAD, CSR_DATA_W'(mp));
      write_csr(CSR_TX_WATCHDOG, wd);
      write_csr(CSR_MAX_RX_WINDOW, rw);
      csr_we <= 1'b0;
   endtask

   // close any open transaction through a failed poll
   task automatic settle_idle();
      if (sb.mode == MODE_TX) send_req(make_req(OP_POLL_TX, 0, 0, 0, 1, 0, 0, 0));
      else if (sb.mode == MODE_RX) send_req(make_req(OP_POLL_RX, 0, 0, 0, 1, 0, 0, 0));
   endtask

   task automatic run_random(input int n, input bit with_hold);
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
         if (with_hold && i == n / 2) begin
            hold_rsp = 1'b1;
            send_quiet = 1'b1;
         end
         send_req(random_item());
      end
   endtask

   task automatic run_ticks(input int n);
      for (int i = 0; i < n; i++) send_req(make_req(OP_TICK, 0, 0, 0, 0, 1, 0, 0));
   endtask

   // result side: random stalls, quiet stretches, one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      int cycle_count;
      bit quiet;
      stall_left = 0;
      hold_left = 0;
      cycle_count = 0;
      quiet = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         cycle_count++;
         if (cycle_count % 128 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (hold_rsp) begin
            hold_left = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 30) begin
            stall_left = idle_len() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      send_req(make_req(OP_POLL_TX, 0, 0, FLAG_TX_DONE, 1, 1, 0, 0));
      send_req(make_req(OP_POLL_RX, 8'hFF, 16'hFFFF, 16'hFFFF, 1, 1, 8'hFF, 8'hFF));
      send_req(make_req(OP_UNDEF_A, 8'hFF, 16'hFFFF, 16'hFFFF, 1, 1, 8'hFF, 8'hFF));
      send_req(make_req(OP_UNDEF_B, 8'h01, 16'h0001, 16'h0001, 0, 0, 8'h01, 8'h01));
      send_req(make_req(OP_START_TX, 0, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_START_TX, 8'd255, 0, 0, 0, 0, 0, 0));
      send_req(make_req(OP_SLEEP, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(OP_SLEEP, 0, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_SLEEP, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(OP_TICK, 0, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_START_RX, 0, 16'd60001, 0, 0, 1, 0, 0));
      send_req(make_req(OP_START_RX, 0, 16'd60000, 0, 0, 1, 0, 0));
      send_req(make_req(OP_START_TX, 8'd10, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_SLEEP, 0, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_RX, 0, 0, 16'h0000, 0, 1, 8'd5, 8'd5));
      send_req(make_req(OP_POLL_RX, 0, 0, 16'h0010, 0, 1, 8'd5, 8'd5));
      send_req(make_req(OP_POLL_RX, 0, 0, 16'hFFFF, 1, 1, 8'd5, 8'd5));
      send_req(make_req(OP_START_RX, 0, 16'd1, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_RX, 0, 0, FLAG_HDR_ERR | FLAG_TIMEOUT | FLAG_RX_DONE,
                        0, 1, 0, 0));
      send_req(make_req(OP_START_RX, 0, 16'd3, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_RX, 0, 0, FLAG_TIMEOUT | FLAG_RX_DONE, 0, 1, 0, 0));
      send_req(make_req(OP_START_RX, 0, 16'd4, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_RX, 0, 0, FLAG_RX_DONE, 0, 1, 8'hFF, 8'hFF));
      send_req(make_req(OP_START_TX, 8'd1, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_TX, 0, 0, 16'hFFFF, 1, 0, 0, 0));
      send_req(make_req(OP_START_TX, 8'd255, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_TX, 0, 0, FLAG_TIMEOUT, 1, 1, 0, 0));

      configure(8'd200, 16'd5, 16'd1000);
      run_random(500, 1'b1);
      configure(8'd1, 16'd1, 16'd1);
      run_random(300, 1'b0);
      configure(8'd255, 16'd65535, 16'd65535);
      run_random(300, 1'b0);
      configure(8'($urandom_range(1, 255)), 16'($urandom_range(1, 40)),
                16'($urandom_range(1, 65535)));
      run_random(400, 1'b0);
      configure(8'($urandom_range(1, 255)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 2000)));
      run_random(400, 1'b0);

      // watchdog beyond the count's range never fires
      send_quiet = 1'b0;
      settle_idle();
      configure(8'd255, 16'd4096, 16'd60000);
      send_req(make_req(OP_START_TX, 8'd1, 0, 0, 0, 1, 0, 0));
      run_ticks(40);
      send_req(make_req(OP_POLL_TX, 0, 0, 0, 0, 1, 0, 0));
      send_req(make_req(OP_POLL_TX, 0, 0, 16'h0004, 1, 1, 0, 0));
      send_req(make_req(OP_POLL_TX, 0, 0, FLAG_TX_DONE, 1, 1, 0, 0));

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
